// ===== sv/fgh_pkg.sv =====
`default_nettype none
package fgh_pkg;

  typedef enum logic [1:0] {
    OP_KIN = 2'd0,
    OP_CPL = 2'd1,
    OP_VEC = 2'd2,
    OP_CMP = 2'd3
  } op_t;

  typedef struct packed {
    op_t                operation;
    logic [8:0]         grid_index;
    logic [2:0]         row_channel;
    logic [2:0]         col_channel;
    logic signed [63:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] product_value;
    logic [2:0]         out_channel;
    logic [8:0]         out_point;
    logic               saturated;
  } out_item_t;

  // queued work for the back end
  typedef struct packed {
    op_t         op;
    logic [8:0]  n;
    logic [2:0]  p;
    logic [2:0]  q;
    logic [63:0] value;
  } job_t;

  typedef struct packed {
    logic        busy;
    logic        sat;
    logic [63:0] acc;
  } mac_stat_t;

  localparam int unsigned FRAC_BITS = 40;

  localparam logic REG_GRID = 1'b0;
  localparam logic REG_CHAN = 1'b1;

  localparam logic [9:0] GRID_RESET = 10'd512;
  localparam logic [3:0] CHAN_RESET = 4'd1;

endpackage
`default_nettype wire

// ===== sv/fgh_front.sv =====
`default_nettype none
module fgh_front #(
  parameter int GRID_MAX    = 512,
  parameter int CHANNEL_MAX = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire fgh_pkg::in_item_t in_item,
  input  wire logic [9:0]       nn,
  input  wire logic [3:0]       cc,
  input  wire logic             pop,
  output logic                  busy,
  output logic                  job_valid,
  output fgh_pkg::job_t         job
);

  localparam logic [12:0] GRID_LIM = 13'(GRID_MAX);
  localparam logic [5:0]  CHAN_LIM = 6'(CHANNEL_MAX);

  fgh_pkg::job_t q_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          legal, push, n_ok, p_ok, q_ok;

  assign n_ok = {4'b0, in_item.grid_index} < GRID_LIM;
  assign p_ok = {3'b0, in_item.row_channel} < CHAN_LIM;
  assign q_ok = {3'b0, in_item.col_channel} < CHAN_LIM;

  // drop loads outside the stores and computes outside the active grid or channels
  always_comb begin
    case (in_item.operation)
      fgh_pkg::OP_KIN: legal = n_ok;
      fgh_pkg::OP_CPL: legal = n_ok && p_ok && q_ok;
      fgh_pkg::OP_VEC: legal = n_ok && p_ok;
      fgh_pkg::OP_CMP: legal = ({1'b0, in_item.grid_index} < nn) &&
                               ({1'b0, in_item.row_channel} < cc);
      default:         legal = 1'b0;
    endcase
  end

  assign busy      = (cnt_r == 2'd2);
  assign push      = start && !busy && legal;
  assign job_valid = (cnt_r != 2'd0);
  assign job       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= '{op: in_item.operation, n: in_item.grid_index,
                         p: in_item.row_channel, q: in_item.col_channel,
                         value: in_item.load_value};
    end
  end

endmodule
`default_nettype wire

// ===== sv/fgh_mac.sv =====
`default_nettype none
module fgh_mac #(
  parameter int VALUE_WIDTH = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   clear,
  input  wire logic                   in_valid,
  input  wire logic [VALUE_WIDTH-1:0] a,
  input  wire logic [VALUE_WIDTH-1:0] b,
  output fgh_pkg::mac_stat_t          stat
);

  localparam int FB = fgh_pkg::FRAC_BITS;
  localparam logic [63:0]  VMAX = 64'({1'b0, {(VALUE_WIDTH-1){1'b1}}});
  localparam logic [63:0]  VMIN = ~VMAX;
  localparam logic [127:0] RND0 = 128'(1) << (FB - 1);
  localparam logic [127:0] RND1 = RND0 + 128'(1);

  logic [5:1] v_r;
  logic [63:0] ma_r, mb_r;
  logic [4:2] neg_r;
  logic [63:0] p00_r, p01_r, p10_r, p11_r;
  logic [127:0] mag_r, rnd_r;
  logic [63:0] term_r, acc_r;
  logic        tsat_r, sat_r;

  logic signed [VALUE_WIDTH-1:0] as, bs;
  logic [63:0]  ax, bx;
  logic [127:0] mag;
  logic         hi_bad;
  logic [64:0]  sum;
  logic         add_bad;

  assign as = a;
  assign bs = b;
  assign ax = 64'(as);
  assign bx = 64'(bs);

  assign mag = 128'(p00_r) + (128'(p01_r) << 32) + (128'(p10_r) << 32) +
               (128'(p11_r) << 64);

  assign hi_bad = rnd_r[127:FB+VALUE_WIDTH-1] !=
                  {(128-FB-VALUE_WIDTH+1){rnd_r[127]}};

  assign sum     = {acc_r[63], acc_r} + {term_r[63], term_r};
  assign add_bad = sum[64:VALUE_WIDTH-1] != {(66-VALUE_WIDTH){sum[64]}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[4:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    // stage 1: magnitudes and product sign
    ma_r     <= ax[63] ? 64'(0) - ax : ax;
    mb_r     <= bx[63] ? 64'(0) - bx : bx;
    neg_r[2] <= ax[63] ^ bx[63];
    // stage 2: four half-width partial products
    p00_r    <= 64'(ma_r[31:0])  * 64'(mb_r[31:0]);
    p01_r    <= 64'(ma_r[31:0])  * 64'(mb_r[63:32]);
    p10_r    <= 64'(ma_r[63:32]) * 64'(mb_r[31:0]);
    p11_r    <= 64'(ma_r[63:32]) * 64'(mb_r[63:32]);
    neg_r[3] <= neg_r[2];
    // stage 3: combine
    mag_r    <= mag;
    neg_r[4] <= neg_r[3];
    // stage 4: apply sign and round half up
    rnd_r    <= neg_r[4] ? (~mag_r + RND1) : (mag_r + RND0);
    // stage 5: drop fraction and clamp
    if (hi_bad) begin
      term_r <= rnd_r[127] ? VMIN : VMAX;
      tsat_r <= 1'b1;
    end else begin
      term_r <= 64'($signed(rnd_r[FB+VALUE_WIDTH-1:FB]));
      tsat_r <= 1'b0;
    end
  end

  // stage 6: saturating accumulate
  always_ff @(posedge clk) begin
    if (clear) begin
      acc_r <= '0;
      sat_r <= 1'b0;
    end else if (v_r[5]) begin
      acc_r <= add_bad ? (sum[64] ? VMIN : VMAX) : sum[63:0];
      sat_r <= sat_r | tsat_r | add_bad;
    end
  end

  assign stat = '{busy: |v_r, sat: sat_r, acc: acc_r};

endmodule
`default_nettype wire

// ===== sv/fgh_back.sv =====
`default_nettype none
module fgh_back #(
  parameter int GRID_MAX    = 512,
  parameter int CHANNEL_MAX = 8,
  parameter int VALUE_WIDTH = 64
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            job_valid,
  input  wire fgh_pkg::job_t   job,
  input  wire logic [9:0]      nn,
  input  wire logic [3:0]      cc,
  output logic                 pop,
  output logic                 out_valid,
  output fgh_pkg::out_item_t   out_item
);

  localparam int KAW = $clog2(GRID_MAX);
  localparam int VAW = $clog2(GRID_MAX * CHANNEL_MAX);
  localparam int CAW = $clog2(GRID_MAX * CHANNEL_MAX * CHANNEL_MAX);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_KIN  = 4'b0010,
    ST_CPL  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  logic [VALUE_WIDTH-1:0] kin_mem [GRID_MAX];
  logic [VALUE_WIDTH-1:0] vec_mem [GRID_MAX*CHANNEL_MAX];
  logic [VALUE_WIDTH-1:0] cpl_mem [GRID_MAX*CHANNEL_MAX*CHANNEL_MAX];

  state_t     state_r, state_nxt;
  logic [8:0] n_r, n_nxt;
  logic [2:0] p_r, p_nxt;
  logic [9:0] m_r, m_nxt;
  logic [3:0] q_r, q_nxt;
  logic       rd_v_r, rd_sel_r;
  logic [VALUE_WIDTH-1:0] kin_rd_r, vec_rd_r, cpl_rd_r;
  logic       out_valid_r, out_valid_nxt;
  fgh_pkg::out_item_t out_item_r;

  logic       issue, clear;
  logic [9:0] d;
  logic [KAW-1:0] kaddr, kwaddr;
  logic [VAW-1:0] vaddr, vwaddr;
  logic [CAW-1:0] caddr, cwaddr;
  fgh_pkg::mac_stat_t stat;

  assign d = ({1'b0, n_r} >= m_r) ? {1'b0, n_r} - m_r : m_r - {1'b0, n_r};
  assign kaddr = KAW'(d);
  assign vaddr = (state_r == ST_KIN)
               ? VAW'(VAW'(p_r) * VAW'(GRID_MAX) + VAW'(m_r))
               : VAW'(VAW'(q_r) * VAW'(GRID_MAX) + VAW'(n_r));
  assign caddr = CAW'((CAW'(n_r) * CAW'(CHANNEL_MAX) + CAW'(p_r)) * CAW'(CHANNEL_MAX)
                      + CAW'(q_r));

  assign kwaddr = KAW'(job.n);
  assign vwaddr = VAW'(VAW'(job.p) * VAW'(GRID_MAX) + VAW'(job.n));
  assign cwaddr = CAW'((CAW'(job.n) * CAW'(CHANNEL_MAX) + CAW'(job.p)) * CAW'(CHANNEL_MAX)
                       + CAW'(job.q));

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    p_nxt         = p_r;
    m_nxt         = m_r;
    q_nxt         = q_r;
    pop           = 1'b0;
    issue         = 1'b0;
    clear         = 1'b0;
    out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        pop = job_valid;
        if (job_valid && job.op == fgh_pkg::OP_CMP) begin
          n_nxt     = job.n;
          p_nxt     = job.p;
          m_nxt     = '0;
          clear     = 1'b1;
          state_nxt = ST_KIN;
        end
      end
      ST_KIN: begin
        issue = 1'b1;
        m_nxt = m_r + 10'd1;
        if (m_r == nn - 10'd1) begin
          q_nxt     = '0;
          state_nxt = ST_CPL;
        end
      end
      ST_CPL: begin
        issue = 1'b1;
        q_nxt = q_r + 4'd1;
        if (q_r == cc - 4'd1) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the last term has left the accumulator
        if (!rd_v_r && !stat.busy) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_v_r      <= issue;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    p_r      <= p_nxt;
    m_r      <= m_nxt;
    q_r      <= q_nxt;
    rd_sel_r <= (state_r == ST_CPL);
    if (out_valid_nxt) begin
      out_item_r <= '{product_value: stat.acc, out_channel: p_r,
                      out_point: n_r, saturated: stat.sat};
    end
  end

  // stores: one write port for loads, one registered read port each
  always_ff @(posedge clk) begin
    if (pop && job.op == fgh_pkg::OP_KIN) kin_mem[kwaddr] <= job.value[VALUE_WIDTH-1:0];
    if (pop && job.op == fgh_pkg::OP_VEC) vec_mem[vwaddr] <= job.value[VALUE_WIDTH-1:0];
    if (pop && job.op == fgh_pkg::OP_CPL) cpl_mem[cwaddr] <= job.value[VALUE_WIDTH-1:0];
    kin_rd_r <= kin_mem[kaddr];
    vec_rd_r <= vec_mem[vaddr];
    cpl_rd_r <= cpl_mem[caddr];
  end

  fgh_mac #(.VALUE_WIDTH(VALUE_WIDTH)) u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (clear),
    .in_valid (rd_v_r),
    .a        (rd_sel_r ? cpl_rd_r : kin_rd_r),
    .b        (vec_rd_r),
    .stat     (stat)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

// ===== sv/fgh_hamiltonian_matvec.sv =====
// Compute: an item accepted into an idle block passes the queue, then its N grid terms and
// C coupling terms enter the MAC one a cycle; the result follows once the MAC has drained.
// The single MAC pipeline starts a compute only after the previous one has finished; loads
// retire one a cycle from a two-entry queue while idle. The receiver cannot stall results.
// Reset (rst_n low at a clock edge) empties the queue, idles the sequencer and sets
// grid_points to 512 and channel_count to 1; the stores keep whatever they held.
`default_nettype none
module fgh_hamiltonian_matvec #(
  parameter int GRID_MAX    = 512,
  parameter int CHANNEL_MAX = 8,
  parameter int VALUE_WIDTH = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // command channel
  input  wire logic              start,
  output logic                   busy,
  input  wire fgh_pkg::in_item_t in_item,
  // results, one-cycle strobe
  output logic                   out_valid,
  output fgh_pkg::out_item_t     out_item,
  // register port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic [9:0] grid_r;
  logic [3:0] chan_r;
  logic [9:0] nn;
  logic [3:0] cc;
  logic       wr;
  logic       job_valid, pop;
  fgh_pkg::job_t job;

  // register write on the access phase; index is the word address
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == fgh_pkg::REG_CHAN) ? {28'b0, chan_r} : {22'b0, grid_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_r <= fgh_pkg::GRID_RESET;
      chan_r <= fgh_pkg::CHAN_RESET;
    end else if (wr) begin
      if (paddr[2] == fgh_pkg::REG_GRID) grid_r <= pwdata[9:0];
      else                               chan_r <= pwdata[3:0];
    end
  end

  // clip active sizes to what the stores hold
  assign nn = (13'(grid_r) < 13'(GRID_MAX)) ? grid_r : 10'(GRID_MAX);
  assign cc = (6'(chan_r) < 6'(CHANNEL_MAX)) ? chan_r : 4'(CHANNEL_MAX);

  // front: accept, drop out-of-range items, queue the rest
  fgh_front #(.GRID_MAX(GRID_MAX), .CHANNEL_MAX(CHANNEL_MAX)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .nn        (nn),
    .cc        (cc),
    .pop       (pop),
    .busy      (busy),
    .job_valid (job_valid),
    .job       (job)
  );

  // back: stores, term sequencer and MAC
  fgh_back #(
    .GRID_MAX    (GRID_MAX),
    .CHANNEL_MAX (CHANNEL_MAX),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job),
    .nn        (nn),
    .cc        (cc),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

// ===== tb/fgh_matvec_checker.sv =====
module fgh_matvec_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  fgh_pkg::in_item_t in_item,
  input  logic              out_valid,
  input  fgh_pkg::out_item_t out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output int                fails,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GMAX = 512;
  localparam int CMAX = 8;
  localparam logic signed [63:0] VMAX = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] VMIN = 64'sh8000_0000_0000_0000;

  logic [63:0] kin_tab [GMAX];
  logic [63:0] cpl_tab [GMAX*CMAX*CMAX];
  logic [63:0] vec_tab [CMAX*GMAX];
  logic [9:0]  grid_reg;
  logic [3:0]  chan_reg;
  bit          clamp_seen;
  fgh_pkg::out_item_t expected_rows[$];

  function automatic logic signed [63:0] fx_product(logic signed [63:0] a,
                                                    logic signed [63:0] b);
    logic signed [127:0] pr;
    logic signed [127:0] sh;
    pr = a;
    pr = pr * b + (128'sd1 <<< 39);
    sh = pr >>> 40;
    if (sh > VMAX) begin
      clamp_seen = 1;
      return VMAX;
    end
    if (sh < VMIN) begin
      clamp_seen = 1;
      return VMIN;
    end
    return sh[63:0];
  endfunction

  function automatic logic signed [63:0] clamp_add(logic signed [63:0] acc,
                                                   logic signed [63:0] t);
    logic signed [64:0] s;
    s = acc;
    s = s + t;
    if (s > VMAX) begin
      clamp_seen = 1;
      return VMAX;
    end
    if (s < VMIN) begin
      clamp_seen = 1;
      return VMIN;
    end
    return s[63:0];
  endfunction

  function automatic fgh_pkg::out_item_t hx_row(int n, int p, int nn, int cc);
    logic signed [63:0] acc;
    fgh_pkg::out_item_t r;
    int d;
    acc = 0;
    clamp_seen = 0;
    for (int m = 0; m < nn; m++) begin
      d = n >= m ? n - m : m - n;
      acc = clamp_add(acc, fx_product(kin_tab[d], vec_tab[p*GMAX + m]));
    end
    for (int q = 0; q < cc; q++)
      acc = clamp_add(acc, fx_product(cpl_tab[(n*CMAX + p)*CMAX + q], vec_tab[q*GMAX + n]));
    r.product_value = acc;
    r.out_channel   = p[2:0];
    r.out_point     = n[8:0];
    r.saturated     = clamp_seen;
    return r;
  endfunction

  always @(posedge clk) begin
    int nn;
    int cc;
    fgh_pkg::out_item_t e;
    if (!rst_n) begin
      grid_reg <= fgh_pkg::GRID_RESET;
      chan_reg <= fgh_pkg::CHAN_RESET;
      fails = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == fgh_pkg::REG_GRID) grid_reg <= pwdata[9:0];
        else chan_reg <= pwdata[3:0];
      end
      if (start && !busy) begin
        nn = grid_reg < GMAX ? grid_reg : GMAX;
        cc = chan_reg < CMAX ? chan_reg : CMAX;
        case (in_item.operation)
          fgh_pkg::OP_KIN: kin_tab[in_item.grid_index] = in_item.load_value;
          fgh_pkg::OP_CPL: cpl_tab[(in_item.grid_index*CMAX + in_item.row_channel)*CMAX
                                   + in_item.col_channel] = in_item.load_value;
          fgh_pkg::OP_VEC: vec_tab[in_item.row_channel*GMAX + in_item.grid_index] =
                             in_item.load_value;
          default: begin
            if (in_item.grid_index < nn && in_item.row_channel < cc)
              expected_rows.push_back(hx_row(in_item.grid_index, in_item.row_channel, nn, cc));
          end
        endcase
      end
      if (out_valid) begin
        if (expected_rows.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected result p=%0d n=%0d", out_item.out_channel, out_item.out_point);
        end else begin
          e = expected_rows.pop_front();
          if (out_item !== e) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: exp val=%h p=%0d n=%0d sat=%b got val=%h p=%0d n=%0d sat=%b",
                       e.product_value, e.out_channel, e.out_point, e.saturated,
                       out_item.product_value, out_item.out_channel, out_item.out_point,
                       out_item.saturated);
          end
        end
      end
    end
    pending = expected_rows.size();
  end
endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GMAX = 512;
  localparam int CMAX = 8;
  localparam logic [63:0] V_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] V_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] V_ONE = 64'h0000_0100_0000_0000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  fgh_pkg::in_item_t  in_item;
  logic        out_valid;
  fgh_pkg::out_item_t out_item;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fails;
  int          pending;
  int          cycles = 0;
  int          burst_left;
  int          grid_now;
  int          chan_now;
  // store entries written so far; a compute only reads written ones
  bit          kin_w [GMAX];
  bit          vec_w [CMAX*GMAX];
  bit          cpl_w [GMAX*CMAX*CMAX];

  fgh_hamiltonian_matvec uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  fgh_matvec_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .psel(psel), .penable(penable),
    .pwrite(pwrite), .pready(pready), .paddr(paddr), .pwdata(pwdata),
    .fails(fails), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Hard limit: a run that does not finish by the cycle limit fails.
  always @(posedge clk) begin
    cycles++;
    if (cycles > 2_000_000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Mostly moderate values near unity so sums stay meaningful; sometimes the extremes
  // or a fully random pattern, so every bit of the value toggles and clamping occurs.
  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    case ($urandom_range(0, 9))
      0: v = V_MAX;
      1: v = V_MIN;
      2, 3: v = {$urandom, $urandom};
      default: begin
        v = {20'b0, 12'($urandom_range(0, 4095)), $urandom};
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  // Present one item and hold it until the block takes it. Between bursts lower
  // start for a random gap; within a burst keep start high for the next item.
  task automatic issue(fgh_pkg::in_item_t it);
    bit took;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
    end else begin
      burst_left--;
    end
    start   <= 1'b1;
    in_item <= it;
    // busy is registered: its value at the falling edge holds at the next rising edge
    do begin
      @(negedge clk);
      took = !busy;
      @(posedge clk);
    end while (!took);
  endtask

  task automatic load_item(fgh_pkg::op_t op, int n, int p, int q, logic [63:0] v);
    fgh_pkg::in_item_t it;
    it.operation   = op;
    it.grid_index  = n[8:0];
    it.row_channel = p[2:0];
    it.col_channel = q[2:0];
    it.load_value  = v;
    case (op)
      fgh_pkg::OP_KIN: kin_w[n] = 1'b1;
      fgh_pkg::OP_CPL: cpl_w[(n*CMAX + p)*CMAX + q] = 1'b1;
      fgh_pkg::OP_VEC: vec_w[p*GMAX + n] = 1'b1;
      default: ;
    endcase
    issue(it);
  endtask

  // Write every entry that a compute for point n, channel p reads and that
  // has not been written yet.
  task automatic prep(int n, int p);
    int d;
    for (int m = 0; m < grid_now; m++) begin
      d = n >= m ? n - m : m - n;
      if (!kin_w[d]) load_item(fgh_pkg::OP_KIN, d, 0, 0, pick_value());
      if (!vec_w[p*GMAX + m]) load_item(fgh_pkg::OP_VEC, m, p, 0, pick_value());
    end
    for (int q = 0; q < chan_now; q++) begin
      if (!cpl_w[(n*CMAX + p)*CMAX + q])
        load_item(fgh_pkg::OP_CPL, n, p, q, pick_value());
      if (!vec_w[q*GMAX + n]) load_item(fgh_pkg::OP_VEC, n, q, 0, pick_value());
    end
  endtask

  // Computes outside N or C are dropped by the block and read nothing.
  task automatic compute_item(int n, int p, int q);
    if (n < grid_now && p < chan_now) prep(n, p);
    load_item(fgh_pkg::OP_CMP, n, p, q, {$urandom, $urandom});
  endtask

  // Drop start, wait for every expected result, then let trailing loads retire
  // before touching the registers.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(int g, int c);
    write_reg({fgh_pkg::REG_GRID, 2'b00}, 32'(g));
    write_reg({fgh_pkg::REG_CHAN, 2'b00}, 32'(c));
    grid_now = g > GMAX ? GMAX : g;
    chan_now = c > CMAX ? CMAX : c;
  endtask

  // One random item. Loads mostly land inside the active grid; a few computes
  // pick any point and channel and are dropped when outside N or C.
  task automatic random_item();
    int kind;
    int n;
    kind = $urandom_range(0, 9);
    if (grid_now == 0 || chan_now == 0) kind = kind % 7;
    if (grid_now > 0 && $urandom_range(0, 3) != 0) n = $urandom_range(0, grid_now - 1);
    else n = $urandom_range(0, 511);
    case (kind)
      0, 1: load_item(fgh_pkg::OP_KIN, n, $urandom_range(0, 7),
                      $urandom_range(0, 7), pick_value());
      2, 3: load_item(fgh_pkg::OP_CPL, n, $urandom_range(0, 7),
                      $urandom_range(0, 7), pick_value());
      4, 5: load_item(fgh_pkg::OP_VEC, n, $urandom_range(0, 7),
                      $urandom_range(0, 7), pick_value());
      6: compute_item($urandom_range(0, 511), $urandom_range(0, 7), $urandom_range(0, 7));
      default: compute_item($urandom_range(0, grid_now - 1),
                            $urandom_range(0, chan_now - 1), $urandom_range(0, 7));
    endcase
  endtask

  initial begin
    int g_list[8];
    int c_list[8];
    int n_list[8];
    g_list = '{2, 12, 24, 0, 5, 1023, 3, 7};
    c_list = '{8, 3, 2, 4, 15, 0, 1, 6};
    n_list = '{30, 40, 30, 20, 20, 15, 30, 25};
    burst_left = 0;
    grid_now   = 512;
    chan_now   = 1;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset config (N 512, C 1): computes on a channel beyond C are dropped.
    compute_item(100, 1, 0);
    compute_item(511, 7, 7);
    settle();

    // Small grid, one channel: clamp a product both ways, then clamp a sum of
    // two unclamped products, then round a negative half towards plus infinity.
    set_config(2, 1);
    compute_item(0, 0, 0);
    load_item(fgh_pkg::OP_KIN, 0, 0, 0, V_MAX);
    load_item(fgh_pkg::OP_VEC, 0, 0, 0, V_MAX);
    compute_item(0, 0, 0);
    load_item(fgh_pkg::OP_KIN, 0, 0, 0, V_MIN);
    compute_item(0, 0, 0);
    load_item(fgh_pkg::OP_KIN, 0, 0, 0, V_ONE);
    load_item(fgh_pkg::OP_KIN, 1, 0, 0, V_ONE);
    load_item(fgh_pkg::OP_VEC, 0, 0, 0, 64'h7000_0000_0000_0000);
    load_item(fgh_pkg::OP_VEC, 1, 0, 0, 64'h7000_0000_0000_0000);
    compute_item(1, 0, 0);
    load_item(fgh_pkg::OP_KIN, 0, 0, 0, 64'd1);
    load_item(fgh_pkg::OP_VEC, 0, 0, 0, 64'hffff_ff80_0000_0000);
    compute_item(0, 0, 0);
    settle();

    // Full channel count, last channel, and a point just past N.
    set_config(2, 8);
    compute_item(1, 7, 0);
    compute_item(0, 7, 0);
    compute_item(2, 0, 0);

    // Random phases across the register settings, extremes among them.
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      set_config(g_list[ph], c_list[ph]);
      for (int i = 0; i < n_list[ph]; i++) random_item();
    end

    settle();
    if (fails == 0 && pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule

// ===== filelist.f =====
sv/fgh_pkg.sv
sv/fgh_front.sv
sv/fgh_mac.sv
sv/fgh_back.sv
sv/fgh_hamiltonian_matvec.sv
tb/fgh_matvec_checker.sv
tb/tb.sv
